[rtl/swcfd_pkg.sv]
// ----------------------------------------------------------------------------
// swcfd_pkg
// Shared types, constants and the CRC-8 step for the sensor word frame decoder.
// ----------------------------------------------------------------------------
package swcfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // byte positions inside the nine byte frame
  localparam logic [3:0] POS_W0_HI  = 4'd0;
  localparam logic [3:0] POS_W0_LO  = 4'd1;
  localparam logic [3:0] POS_W0_CRC = 4'd2;
  localparam logic [3:0] POS_W1_HI  = 4'd3;
  localparam logic [3:0] POS_W1_LO  = 4'd4;
  localparam logic [3:0] POS_W1_CRC = 4'd5;
  localparam logic [3:0] POS_W2_HI  = 4'd6;
  localparam logic [3:0] POS_W2_LO  = 4'd7;
  localparam logic [3:0] POS_W2_CRC = 4'd8;
  localparam logic [3:0] POS_LAST   = POS_W2_CRC;

  // conversion constants
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  typedef struct packed {
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [15:0] third_word;
    logic        crc_good;
    logic        all_words_zero;
  } frame_res_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/sensor_word_crc_frame_decoder_top.sv]
// ----------------------------------------------------------------------------
// sensor_word_crc_frame_decoder_top
// Decodes a nine byte sensor reply of three CRC-8 protected words into raw
// words, scaled temperature and humidity, and CRC and no-device flags.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while in_stall is low. Each beat passes
// an input register and, on the ninth byte of a frame, moves on into the
// result register as it leaves the input register. Bytes that do not close
// a frame keep flowing while a result waits on out_stall; only a closing
// byte is held until the result register frees up. Every ninth byte after
// the last in_frame_start beat yields a result, and a new in_frame_start
// beat drops any partial frame.
module sensor_word_crc_frame_decoder_top
  import swcfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_first_word,
  output logic [15:0]        out_second_word,
  output logic [15:0]        out_third_word,
  output logic signed [14:0] out_temp_centi_deg,
  output logic [13:0]        out_humidity_centi_pct,
  output logic               out_crc_good,
  output logic               out_all_words_zero
);

  frame_res_t         res;
  logic               res_fire;
  logic               res_free;
  logic signed [14:0] temp_val;
  logic [13:0]        hum_val;

  logic               out_vld_r;
  frame_res_t         out_res_r;
  logic signed [14:0] out_temp_r;
  logic [13:0]        out_hum_r;

  assign res_free = !out_vld_r || !out_stall;

  swcfd_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .res_free       (res_free),
    .res_fire       (res_fire),
    .res            (res)
  );

  swcfd_scale u_scale (
    .temp_code          (res.second_word),
    .hum_code           (res.third_word),
    .temp_centi_deg     (temp_val),
    .humidity_centi_pct (hum_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      if (res_fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_res_r  <= res;
      out_temp_r <= temp_val;
      out_hum_r  <= hum_val;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_first_word         = out_res_r.first_word;
  assign out_second_word        = out_res_r.second_word;
  assign out_third_word         = out_res_r.third_word;
  assign out_temp_centi_deg     = out_temp_r;
  assign out_humidity_centi_pct = out_hum_r;
  assign out_crc_good           = out_res_r.crc_good;
  assign out_all_words_zero     = out_res_r.all_words_zero;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> !out_vld_r || !out_stall)
    else $error("result register overwritten while stalled");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(res_fire))
    else $error("result beat without a closing byte");

endmodule

[rtl/swcfd_frame.sv]
// ----------------------------------------------------------------------------
// swcfd_frame
// Input register, byte position tracking, per-word CRC-8 check and word
// assembly. Flags the closing byte of each frame with the assembled result.
// ----------------------------------------------------------------------------
module swcfd_frame
  import swcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_start,
  input  logic       res_free,
  output logic       res_fire,
  output frame_res_t res
);

  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        fail_r, fail_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [15:0] w0_r, w0_nxt;
  logic [15:0] w1_r, w1_nxt;

  logic        restart;
  logic [3:0]  pos_eff;
  logic        fail_base;
  logic        is_last;
  logic        s1_fire;
  logic [15:0] w2;

  always_comb begin
    restart   = s1_start_r || (pos_r > POS_LAST);
    pos_eff   = restart ? POS_W0_HI : pos_r;
    fail_base = (pos_eff == POS_W0_HI) ? 1'b0 : fail_r;
    is_last   = (pos_eff == POS_LAST);
    pos_nxt   = is_last ? POS_W0_HI : pos_eff + 4'd1;
    crc_nxt   = crc_r;
    fail_nxt  = fail_base;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    w0_nxt    = w0_r;
    w1_nxt    = w1_r;
    case (pos_eff)
      POS_W0_HI, POS_W1_HI, POS_W2_HI: begin
        crc_nxt = crc8_feed(CRC_INIT, s1_byte_r);
        hi_nxt  = s1_byte_r;
      end
      POS_W0_LO: begin
        crc_nxt = crc8_feed(crc_r, s1_byte_r);
        w0_nxt  = {hi_r, s1_byte_r};
      end
      POS_W1_LO: begin
        crc_nxt = crc8_feed(crc_r, s1_byte_r);
        w1_nxt  = {hi_r, s1_byte_r};
      end
      POS_W2_LO: begin
        crc_nxt = crc8_feed(crc_r, s1_byte_r);
        lo_nxt  = s1_byte_r;
      end
      POS_W0_CRC, POS_W1_CRC, POS_W2_CRC: begin
        fail_nxt = fail_base | (crc_r != s1_byte_r);
        crc_nxt  = CRC_INIT;
      end
      default: begin
        crc_nxt = crc_r;
      end
    endcase
  end

  assign s1_fire  = s1_vld_r && (!is_last || res_free);
  assign in_stall = s1_vld_r && !s1_fire;
  assign res_fire = s1_fire && is_last;

  assign w2                 = {hi_r, lo_r};
  assign res.first_word     = w0_r;
  assign res.second_word    = w1_r;
  assign res.third_word     = w2;
  assign res.crc_good       = !fail_nxt;
  assign res.all_words_zero = (w0_r == 16'd0) && (w1_r == 16'd0) && (w2 == 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      pos_r    <= POS_W0_HI;
      crc_r    <= CRC_INIT;
      fail_r   <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (s1_fire) begin
        pos_r  <= pos_nxt;
        crc_r  <= crc_nxt;
        fail_r <= fail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
    if (s1_fire) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
      w0_r <= w0_nxt;
      w1_r <= w1_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position out of frame range");

  a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_start_r |=> pos_r == POS_W0_LO)
    else $error("restart beat did not land on the second frame position");

  a_crc_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (pos_eff == POS_W0_CRC || pos_eff == POS_W1_CRC || pos_eff == POS_W2_CRC)
    |=> crc_r == CRC_INIT)
    else $error("crc not reloaded after a crc beat");

endmodule

[rtl/swcfd_scale.sv]
// ----------------------------------------------------------------------------
// swcfd_scale
// Converts the temperature and humidity codes to centi-degrees and
// centi-percent by constant multiply and exact floor division by 65535.
// ----------------------------------------------------------------------------
module swcfd_scale
  import swcfd_pkg::*;
(
  input  logic [15:0]        temp_code,
  input  logic [15:0]        hum_code,
  output logic signed [14:0] temp_centi_deg,
  output logic [13:0]        humidity_centi_pct
);

  logic [30:0] t_prod;
  logic [14:0] t_q0;
  logic [16:0] t_rem;
  logic [14:0] t_quo;
  logic [29:0] h_prod;
  logic [13:0] h_q0;
  logic [16:0] h_rem;

  // x / 65535: start from x >> 16, remainder is x[15:0] + q0, one correction
  always_comb begin
    t_prod = 31'(temp_code) * 31'(TEMP_SPAN);
    t_q0   = t_prod[30:16];
    t_rem  = {1'b0, t_prod[15:0]} + {2'b00, t_q0};
    t_quo  = t_q0 + 15'(t_rem >= FULL_SCALE);
    temp_centi_deg = signed'(t_quo - TEMP_OFFSET);

    h_prod = 30'(hum_code) * 30'(HUM_SPAN);
    h_q0   = h_prod[29:16];
    h_rem  = {1'b0, h_prod[15:0]} + {3'b000, h_q0};
    humidity_centi_pct = h_q0 + 14'(h_rem >= FULL_SCALE);
  end

endmodule
